// ===== rtl/pmvb_pkg.sv =====
// Shared types and constants for the per-pixel majority-vote background estimator.
`default_nettype none

package pmvb_pkg;

	localparam int unsigned DEF_MAX_PIXELS = 1048576;
	localparam int unsigned DEF_VOTE_BITS  = 16;

	localparam int unsigned DIM_W   = 11;
	localparam int unsigned DIM_MAX = 1024;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned NUM_CH  = 3;

	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              first_frame;
	} pixel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] bg_red;
		logic [CHAN_W-1:0] bg_green;
		logic [CHAN_W-1:0] bg_blue;
		logic              frame_end;
	} bg_t;

endpackage

`default_nettype wire

// ===== rtl/pmvb_cfg_regs.sv =====
// APB frame geometry registers and the derived index of the last pixel in a frame.
`default_nettype none

module pmvb_cfg_regs #(
	parameter int unsigned MAX_PIXELS = pmvb_pkg::DEF_MAX_PIXELS,
	parameter int unsigned PW         = 20
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [pmvb_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [pmvb_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [pmvb_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	output logic      [PW-1:0]                   last_idx
);
	import pmvb_pkg::*;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] width_c;
	logic [DIM_W-1:0] height_c;
	logic [2*DIM_W-1:0] prod;
	logic [31:0]        total;
	logic               wr_en;
	reg_idx_t           idx;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > DIM_MAX) begin
			r = DIM_W'(DIM_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_FRAME_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_q);
			REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	// pixels per frame, capped at the store depth; never zero
	always_comb begin
		width_c  = clamp_dim(width_q);
		height_c = clamp_dim(height_q);
		prod     = (2*DIM_W)'(width_c) * (2*DIM_W)'(height_c);
		total    = (32'(prod) > 32'(MAX_PIXELS)) ? 32'(MAX_PIXELS) : 32'(prod);
		last_idx = PW'(total - 32'd1);
	end

endmodule

`default_nettype wire

// ===== rtl/pmvb_pos.sv =====
// Raster position counter with end-of-frame detection.
`default_nettype none

module pmvb_pos #(
	parameter int unsigned PW = 20
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire logic [PW-1:0] last_idx,
	output logic      [PW-1:0] pos,
	output logic               last
);
	logic [PW-1:0] pos_q;

	assign pos  = pos_q;
	// ">=" so a geometry shrink mid-frame still wraps
	assign last = pos_q >= last_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (advance) begin
			pos_q <= last ? '0 : pos_q + PW'(1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pmvb_vote_ch.sv =====
// Majority-vote update of one color channel: candidate and saturating vote count.
`default_nettype none

module pmvb_vote_ch #(
	parameter int unsigned VOTE_BITS = pmvb_pkg::DEF_VOTE_BITS
) (
	input  wire logic [pmvb_pkg::CHAN_W-1:0] px,
	input  wire logic                        init,
	input  wire logic [pmvb_pkg::CHAN_W-1:0] old_bg,
	input  wire logic [VOTE_BITS-1:0]        old_vote,
	output logic      [pmvb_pkg::CHAN_W-1:0] new_bg,
	output logic      [VOTE_BITS-1:0]        new_vote
);
	always_comb begin
		new_bg   = old_bg;
		new_vote = old_vote;
		if (init) begin
			new_bg   = px;
			new_vote = VOTE_BITS'(1);
		end else if (px == old_bg) begin
			if (old_vote != '1) begin
				new_vote = old_vote + VOTE_BITS'(1);
			end
		end else if (old_vote == '0) begin
			new_bg   = px;
			new_vote = VOTE_BITS'(1);
		end else begin
			new_vote = old_vote - VOTE_BITS'(1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pixel_majority_vote_background.sv =====
// Per-pixel majority-vote background estimator, top level.
// Path: stage 1 registers the pixel and its store read; the output register takes the update.
// Throughput: one pixel per cycle when not stalled, set by the single read-modify-write pass.
// Reset: clears position, valid flags and frame geometry (640 x 480); the stores are not
// cleared, so each position must be written by a first-frame pixel before it is voted on.
`default_nettype none

module pixel_majority_vote_background #(
	parameter int unsigned MAX_PIXELS = pmvb_pkg::DEF_MAX_PIXELS,
	parameter int unsigned VOTE_BITS  = pmvb_pkg::DEF_VOTE_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// pixel input channel
	input  wire logic                            pix_valid,
	output logic                                 pix_stall,
	input  wire pmvb_pkg::pixel_t                pix,
	// background output channel
	output logic                                 bg_valid,
	input  wire logic                            bg_stall,
	output pmvb_pkg::bg_t                        bg,
	// configuration
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [pmvb_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [pmvb_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [pmvb_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready
);
	import pmvb_pkg::*;

	localparam int unsigned PW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

	// One store entry: three candidates and three vote counts.
	typedef struct packed {
		logic [NUM_CH-1:0][CHAN_W-1:0]    bgc;
		logic [NUM_CH-1:0][VOTE_BITS-1:0] votes;
	} entry_t;

	logic [PW-1:0] last_idx;
	logic [PW-1:0] pos;
	logic          pos_last;

	logic          accept;
	logic          out_free;
	logic          wb;

	// stage 1: pixel, its position, and the store word read for it
	logic          s1_valid_q;
	pixel_t        pix_s1;
	logic [PW-1:0] addr_s1;
	logic          last_s1;
	entry_t        rd_s1;
	logic          fwd_s1;
	entry_t        fwd_data_s1;

	entry_t        old_entry;
	entry_t        new_entry;
	logic [NUM_CH-1:0][CHAN_W-1:0] px_ch;

	logic          bg_valid_q;
	bg_t           bg_q;

	entry_t        mem [0:MAX_PIXELS-1];

	pmvb_cfg_regs #(
		.MAX_PIXELS (MAX_PIXELS),
		.PW         (PW)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.last_idx (last_idx)
	);

	pmvb_pos #(
		.PW (PW)
	) u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (accept),
		.last_idx (last_idx),
		.pos      (pos),
		.last     (pos_last)
	);

	// Handshake: the output register frees stage 1, stage 1 frees the input.
	assign out_free  = !bg_valid_q || !bg_stall;
	assign wb        = s1_valid_q && out_free;
	assign pix_stall = s1_valid_q && !out_free;
	assign accept    = pix_valid && !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (out_free) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Stage 1 payload. When the pixel ahead writes the same position at this
	// edge (tiny frames), its fresh word is captured instead of the stale read.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pix;
			addr_s1     <= pos;
			last_s1     <= pos_last;
			fwd_s1      <= s1_valid_q && (addr_s1 == pos);
			fwd_data_s1 <= new_entry;
		end
	end

	// Store read port: registered read at the pixel transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[pos];
		end
	end

	// Store write port: write-back as the result leaves stage 1
	always_ff @(posedge clk) begin
		if (wb) begin
			mem[addr_s1] <= new_entry;
		end
	end

	assign old_entry = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign px_ch[0]  = pix_s1.red;
	assign px_ch[1]  = pix_s1.green;
	assign px_ch[2]  = pix_s1.blue;

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
		pmvb_vote_ch #(
			.VOTE_BITS (VOTE_BITS)
		) u_vote (
			.px       (px_ch[ch]),
			.init     (pix_s1.first_frame),
			.old_bg   (old_entry.bgc[ch]),
			.old_vote (old_entry.votes[ch]),
			.new_bg   (new_entry.bgc[ch]),
			.new_vote (new_entry.votes[ch])
		);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_valid_q <= 1'b0;
		end else if (out_free) begin
			bg_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wb) begin
			bg_q.bg_red    <= new_entry.bgc[0];
			bg_q.bg_green  <= new_entry.bgc[1];
			bg_q.bg_blue   <= new_entry.bgc[2];
			bg_q.frame_end <= last_s1;
		end
	end

	assign bg_valid = bg_valid_q;
	assign bg       = bg_q;

	// The input is only held off by a full, blocked stage 1.
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> !pix_stall)
		else $error("pixel stall without a pending stage-1 pixel");

	// A stage-1 write-back always produces a result next cycle.
	a_wb_presents: assert property (@(posedge clk) disable iff (!arst_n)
		wb |=> bg_valid_q)
		else $error("write-back without an output result");

	// Forwarding only happens from a pixel that was ahead in stage 1.
	a_fwd_source: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fwd_s1 && s1_valid_q) |-> $past(s1_valid_q) || !$past(accept))
		else $error("forwarded store word without a preceding pixel");

	// Position wraps to zero after the last pixel of a frame.
	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos_last) |=> (pos == '0))
		else $error("position did not wrap at end of frame");

	// Position advances by one on an ordinary transfer.
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !pos_last) |=> (pos == $past(pos) + PW'(1)))
		else $error("position did not advance");

endmodule

`default_nettype wire

// ===== sim/tb_pixel_majority_vote_background.sv =====
// Self-checking testbench for the per-pixel majority-vote background estimator.
`timescale 1ns / 100ps

module tb_pixel_majority_vote_background;

	import pmvb_pkg::*;

	localparam int unsigned MAX_PIX  = DEF_MAX_PIXELS;
	localparam int unsigned VOTE_W   = DEF_VOTE_BITS;
	localparam int unsigned HOLD_LEN = 200;   // long receiver hold-off, in cycles
	localparam int unsigned IDLE_PCT = 11;

	// DUT hookup; every input starts at a known value
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_stall;
	pixel_t                pix       = '0;
	logic                  bg_valid;
	logic                  bg_stall  = 1'b0;
	bg_t                   bg;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [APB_ADDR_W-1:0] paddr     = '0;
	logic [APB_DATA_W-1:0] pwdata    = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	pixel_majority_vote_background #(
		.MAX_PIXELS(MAX_PIX),
		.VOTE_BITS (VOTE_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix      (pix),
		.bg_valid (bg_valid),
		.bg_stall (bg_stall),
		.bg       (bg),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Frame geometry as last written (shared by the stimulus side and the predictor).
	logic [DIM_W-1:0] cfg_width  = FRAME_WIDTH_RST;
	logic [DIM_W-1:0] cfg_height = FRAME_HEIGHT_RST;

	// Predictor state: candidate and vote count per position and channel.
	logic [NUM_CH-1:0][CHAN_W-1:0] cand_mem [int unsigned];
	logic [NUM_CH-1:0][VOTE_W-1:0] vote_mem [int unsigned];
	int unsigned                   vote_pos = 0;

	// Stimulus side: its own walk over positions, so that a position is always
	// seeded by a first-frame pixel before it is voted on.
	int unsigned                   gen_pos = 0;
	bit                            pos_seeded [int unsigned];
	logic [NUM_CH-1:0][CHAN_W-1:0] scene      [int unsigned];

	pixel_t pix_pending [$];
	bg_t    bg_expected [$];

	// Handshake pressure controls
	bit steady   = 1'b0;   // no idling on either side while set
	int hold_req = 0;      // bump to ask the receiver for one long hold-off
	int hold_seen = 0;
	int unsigned hold_left = 0;

	int unsigned pix_accepted = 0;
	int unsigned bg_checked   = 0;
	int unsigned frame_ends   = 0;
	int unsigned reg_writes   = 0;
	int unsigned fail_cnt     = 0;

	initial begin : clock_gen
		forever #5 clk = ~clk;
	end

	// Pixels per frame after clamping both dimensions into 1..1024.
	function automatic int unsigned frame_total();
		int unsigned w, h, n;
		w = (cfg_width == 0) ? 1 : (cfg_width > DIM_MAX) ? DIM_MAX : cfg_width;
		h = (cfg_height == 0) ? 1 : (cfg_height > DIM_MAX) ? DIM_MAX : cfg_height;
		n = w * h;
		if (n > MAX_PIX)
			n = MAX_PIX;
		return n;
	endfunction

	// Boyer-Moore vote on one accepted pixel; returns the background it should produce.
	function automatic bg_t vote_pixel(pixel_t p);
		logic [NUM_CH-1:0][CHAN_W-1:0] px, cand;
		logic [NUM_CH-1:0][VOTE_W-1:0] votes;
		int unsigned pos, total;
		bg_t r;
		total = frame_total();
		pos = (vote_pos >= MAX_PIX) ? 0 : vote_pos;
		px = {p.blue, p.green, p.red};   // index 0 is red
		cand = cand_mem.exists(pos) ? cand_mem[pos] : '0;
		votes = vote_mem.exists(pos) ? vote_mem[pos] : '0;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			if (p.first_frame) begin
				cand[ch] = px[ch];
				votes[ch] = 1;
			end else if (px[ch] == cand[ch]) begin
				if (votes[ch] != '1)   // saturate
					votes[ch] = votes[ch] + 1'b1;
			end else if (votes[ch] == 0) begin
				cand[ch] = px[ch];
				votes[ch] = 1;
			end else begin
				votes[ch] = votes[ch] - 1'b1;
			end
		end
		cand_mem[pos] = cand;
		vote_mem[pos] = votes;
		r.bg_red    = cand[0];
		r.bg_green  = cand[1];
		r.bg_blue   = cand[2];
		r.frame_end = (pos >= total - 1);
		vote_pos = r.frame_end ? 0 : pos + 1;
		return r;
	endfunction

	// Queue one pixel; forces first_frame where the position was never seeded.
	function automatic void queue_pixel(logic [CHAN_W-1:0] r, g, b, bit seed);
		if (!pos_seeded.exists(gen_pos))
			seed = 1'b1;
		if (seed)
			pos_seeded[gen_pos] = 1'b1;
		pix_pending.push_back('{red: r, green: g, blue: b, first_frame: seed});
		gen_pos = (gen_pos >= frame_total() - 1) ? 0 : gen_pos + 1;
	endfunction

	// Mostly the position's own scene value, sometimes a near miss or noise,
	// so that votes build up, drain and get replaced.
	function automatic void queue_scene_pixel();
		logic [NUM_CH-1:0][CHAN_W-1:0] v;
		if (!scene.exists(gen_pos) || $urandom_range(99) < 2)
			scene[gen_pos] = $urandom;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			case ($urandom_range(9))
				6, 7: v[ch] = scene[gen_pos][ch] ^ (8'h01 << $urandom_range(7));
				8, 9: v[ch] = $urandom;
				default: v[ch] = scene[gen_pos][ch];
			endcase
		end
		queue_pixel(v[0], v[1], v[2], $urandom_range(99) < 4);
	endfunction

	// APB write: setup, then access until pready. Only called while idle.
	task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'(4 * idx);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			cfg_width = value[DIM_W-1:0];
		else
			cfg_height = value[DIM_W-1:0];
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic set_geometry(logic [APB_DATA_W-1:0] w, logic [APB_DATA_W-1:0] h);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	// Sender pause: nothing pending, nothing offered, every result back.
	task automatic wait_drained();
		do @(negedge clk);
		while (pix_pending.size() != 0 || pix_valid || bg_expected.size() != 0);
	endtask

	// Pixel driver: predicts on every transfer, then offers the next pixel
	// unless it idles. A stalled pixel is held as is.
	always @(posedge clk or negedge arst_n) begin : pix_driver
		logic offer;
		if (!arst_n) begin
			pix_valid <= 1'b0;
			pix       <= '0;
		end else begin
			if (pix_valid && !pix_stall) begin
				bg_expected.push_back(vote_pixel(pix));
				pix_accepted++;
			end
			if (!pix_valid || !pix_stall) begin
				offer = (pix_pending.size() != 0) &&
					(steady || $urandom_range(99) >= IDLE_PCT);
				pix_valid <= offer;
				if (offer)
					pix <= pix_pending.pop_front();
			end
		end
	end

	// Background monitor: checks each transfer against the oldest prediction
	// and drives the stall, including the long hold-off on request.
	always @(posedge clk or negedge arst_n) begin : bg_monitor
		bg_t want;
		if (!arst_n) begin
			bg_stall <= 1'b0;
		end else begin
			if (bg_valid && !bg_stall) begin
				if (bg_expected.size() == 0) begin
					$error("background transfer with nothing expected: %p", bg);
					fail_cnt++;
				end else begin
					want = bg_expected.pop_front();
					bg_checked++;
					if (want.frame_end)
						frame_ends++;
					if (bg.bg_red !== want.bg_red) begin
						$error("bg_red: expected %0h, got %0h", want.bg_red, bg.bg_red);
						fail_cnt++;
					end
					if (bg.bg_green !== want.bg_green) begin
						$error("bg_green: expected %0h, got %0h", want.bg_green, bg.bg_green);
						fail_cnt++;
					end
					if (bg.bg_blue !== want.bg_blue) begin
						$error("bg_blue: expected %0h, got %0h", want.bg_blue, bg.bg_blue);
						fail_cnt++;
					end
					if (bg.frame_end !== want.frame_end) begin
						$error("frame_end: expected %0b, got %0b",
							want.frame_end, bg.frame_end);
						fail_cnt++;
					end
				end
			end
			if (hold_left != 0) begin
				bg_stall <= 1'b1;
				hold_left--;
			end else if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_LEN - 1;
				bg_stall <= 1'b1;
			end else begin
				bg_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	initial begin : stimulus
		logic [DIM_W-1:0]      w, h;
		logic [APB_DATA_W-1:0] junk;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset geometry (640 x 480): seed a few positions with the extremes.
		queue_pixel(8'h00, 8'h00, 8'h00, 1'b1);
		queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
		queue_pixel(8'h80, 8'h01, 8'h7F, 1'b1);
		queue_pixel(8'h01, 8'h80, 8'hFE, 1'b1);
		queue_pixel(8'h55, 8'hAA, 8'h33, 1'b1);
		wait_drained();

		// Shrink to 2 x 2 while the position sits past the new last pixel:
		// that pixel must close the frame and wrap.
		set_geometry(2, 2);
		queue_pixel(8'h12, 8'h34, 8'h56, 1'b0);
		// Three frames over the four seeded positions: match, lose a vote,
		// replace at zero votes, then win votes again.
		queue_pixel(8'h00, 8'h00, 8'h00, 1'b0);
		queue_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
		queue_pixel(8'h80, 8'h01, 8'h7F, 1'b0);
		queue_pixel(8'h01, 8'h81, 8'hFE, 1'b0);
		queue_pixel(8'h01, 8'h00, 8'h00, 1'b0);
		queue_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
		queue_pixel(8'h7F, 8'h01, 8'h7F, 1'b0);
		queue_pixel(8'h01, 8'h81, 8'hFE, 1'b0);
		queue_pixel(8'h01, 8'h00, 8'h00, 1'b0);
		queue_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
		queue_pixel(8'h7F, 8'h01, 8'h7F, 1'b0);
		queue_pixel(8'h01, 8'h81, 8'hFE, 1'b1);
		wait_drained();

		// Out-of-range values clamp: 2047 x 0 becomes a 1024-pixel single row.
		set_geometry(11'h7FF, 0);
		repeat (40) queue_scene_pixel();
		wait_drained();

		// Same pixel count as a single column; the position carries on.
		set_geometry(1, DIM_MAX);
		repeat (40) queue_scene_pixel();
		wait_drained();

		// Full 1024 x 1024, then shrink mid-frame.
		set_geometry(DIM_MAX, DIM_MAX);
		repeat (20) queue_scene_pixel();
		wait_drained();
		set_geometry(3, 3);
		repeat (12) queue_scene_pixel();
		wait_drained();

		// One-pixel frames: build up votes on a single position, then
		// mismatches must only take votes away, never replace.
		set_geometry(1, 1);
		queue_pixel(8'h00, 8'h00, 8'h00, 1'b1);
		queue_pixel(8'hC3, 8'h3C, 8'h5A, 1'b1);
		repeat (20) queue_pixel(8'hC3, 8'h3C, 8'h5A, 1'b0);
		repeat (3) queue_pixel(8'h3C, 8'hC3, 8'hA5, 1'b0);
		wait_drained();

		// Random part in four chunks of small frames, each drained before the
		// next geometry: first with a clamped zero width, then one under a long
		// receiver hold-off, then one with no idling at all.
		for (int c = 0; c < 4; c++) begin
			w = (c == 0) ? 0 : $urandom_range(1, 6);
			h = $urandom_range(1, 5);
			junk = $urandom;
			write_reg(REG_FRAME_WIDTH, {junk[APB_DATA_W-1:DIM_W], w});
			junk = $urandom;
			write_reg(REG_FRAME_HEIGHT, {junk[APB_DATA_W-1:DIM_W], h});
			steady = (c == 2);
			repeat (60) queue_scene_pixel();
			if (c == 1)
				hold_req++;
			wait_drained();
			steady = 1'b0;
		end

		// Let anything stray show up before judging.
		repeat (10) @(negedge clk);
		$display("Covered: %0d pixels over %0d register writes, clamped and mid-frame geometry,",
			pix_accepted, reg_writes);
		$display("vote build-up and decay; %0d results checked, %0d frame ends, %0d mismatches.",
			bg_checked, frame_ends, fail_cnt);
		if (fail_cnt == 0 && bg_expected.size() == 0) begin
			$display("tb_pixel_majority_vote_background OK");
		end else begin
			$display("tb_pixel_majority_vote_background NOT OK");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin : watchdog
		#2_000_000;
		$display("tb_pixel_majority_vote_background NOT OK");
		$finish;
	end

endmodule

// ===== pixel_majority_vote_background.f =====
rtl/pmvb_pkg.sv
rtl/pmvb_cfg_regs.sv
rtl/pmvb_pos.sv
rtl/pmvb_vote_ch.sv
rtl/pixel_majority_vote_background.sv
sim/tb_pixel_majority_vote_background.sv
